FILE: hw/rtl/tsda_pkg.sv
package tsda_pkg;

    // terminal characters
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_FOUR     = 8'h34;
    localparam logic [7:0] CH_FIVE     = 8'h35;
    localparam logic [7:0] CH_EIGHT    = 8'h38;
    localparam logic [7:0] CH_LOWER_M  = 8'h6D;
    localparam logic [7:0] CH_UPPER_H  = 8'h48;
    localparam logic [3:0] DIGIT_HI    = 4'h3;

    // utf-8 of the private-use glyph range: lead byte is fixed
    localparam logic [7:0] UTF8_LEAD   = 8'hEE;
    localparam logic [1:0] UTF8_CONT   = 2'b10;

    // byte sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_C_ESC,
        ST_C_LB,
        ST_C_KIND,
        ST_C_8,
        ST_C_SEMI1,
        ST_C_5,
        ST_C_SEMI2,
        ST_C_D2,
        ST_C_D1,
        ST_C_D0,
        ST_C_M,
        ST_M_ESC,
        ST_M_LB,
        ST_M_ROW1,
        ST_M_ROW0,
        ST_M_SEMI,
        ST_M_COL1,
        ST_M_COL0,
        ST_M_H,
        ST_G0,
        ST_G1,
        ST_G2
    } tsda_step_t;

    // everything the sequencer needs to stream one changed cell
    typedef struct packed {
        logic        has_bg;
        logic [11:0] bg_bcd;
        logic        has_move;
        logic [7:0]  row_bcd;
        logic [7:0]  col_bcd;
        logic        has_fg;
        logic [11:0] fg_bcd;
        logic        page_hi;
        logic [7:0]  ch;
    } tsda_job_t;

    // 256-colour index for each low nibble, as three bcd digits
    function automatic logic [11:0] palette_bcd(input logic [3:0] idx);
        logic [11:0] val;
        case (idx)
            4'd0:    val = 12'h000;
            4'd1:    val = 12'h015;
            4'd2:    val = 12'h088;
            4'd3:    val = 12'h109;
            4'd4:    val = 12'h092;
            4'd5:    val = 12'h070;
            4'd6:    val = 12'h018;
            4'd7:    val = 12'h185;
            4'd8:    val = 12'h094;
            4'd9:    val = 12'h052;
            4'd10:   val = 12'h138;
            4'd11:   val = 12'h240;
            4'd12:   val = 12'h244;
            4'd13:   val = 12'h150;
            4'd14:   val = 12'h062;
            4'd15:   val = 12'h248;
            default: val = 12'h000;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/text_screen_diff_to_ansi.sv
// Streams a text screen as ANSI terminal bytes, sending only the cells that
// changed since the previous frame. Cells arrive in row order, one
// transaction each, starting at the top-left cell; frame_bg and force_redraw
// are looked at only on a frame's first cell. An unchanged cell produces
// nothing. A changed cell produces 3 to 33 bytes (cursor move, foreground
// colour, utf-8 glyph, plus the background sequence on a redrawing frame
// start) at one byte per cycle while out_ready is high, so that sustained
// rate is set by the byte sequencer on the output. The shadow copy of the
// screen sits in one read-first memory with a single port: each accepted
// cell reads the old contents and writes its own in the same cycle, so
// consecutive cells never collide. One further cell is held and compared
// while the previous one is still streaming. The first frame after reset
// always redraws the whole screen, so the memory needs no clearing pass.
// charset_upper (reset 1) picks glyph base 0xE000 (1) or 0xE100 (0).
module text_screen_diff_to_ansi #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] cell_char,
    input  logic [7:0] cell_color,
    input  logic [7:0] frame_bg,
    input  logic       force_redraw,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_byte
);

    import tsda_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CLW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    // cursor holds the column after the last one written, plus one
    localparam int CUW   = $clog2(COLUMNS + 2);

    // two-digit bcd increment for the 1-based row and column text
    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [7:0] r;
        if (v[3:0] == 4'd9)
        begin
            r = {v[7:4] + 4'd1, 4'd0};
        end
        else
        begin
            r = {v[7:4], v[3:0] + 4'd1};
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    logic charset_upper_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charset_upper_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            charset_upper_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // cell position: binary for the memory, bcd for the cursor text
    // ---------------------------------------------------------------
    logic [CLW-1:0] col_reg;
    logic [RW-1:0]  row_reg;
    logic [AW-1:0]  addr_reg;
    logic [7:0]     col_bcd_reg;
    logic [7:0]     row_bcd_reg;
    logic           in_accept;
    logic           wrap_col;
    logic           wrap_row;

    assign in_accept = in_valid && in_ready;
    assign wrap_col  = (col_reg == CLW'(COLUMNS - 1));
    assign wrap_row  = (row_reg == RW'(ROWS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            addr_reg    <= '0;
            col_bcd_reg <= 8'h01;
            row_bcd_reg <= 8'h01;
        end
        else if (in_accept)
        begin
            if (wrap_col)
            begin
                col_reg     <= '0;
                col_bcd_reg <= 8'h01;
                if (wrap_row)
                begin
                    row_reg     <= '0;
                    row_bcd_reg <= 8'h01;
                    addr_reg    <= '0;
                end
                else
                begin
                    row_reg     <= row_reg + RW'(1);
                    row_bcd_reg <= bcd_inc(row_bcd_reg);
                    addr_reg    <= addr_reg + AW'(1);
                end
            end
            else
            begin
                col_reg     <= col_reg + CLW'(1);
                col_bcd_reg <= bcd_inc(col_bcd_reg);
                addr_reg    <= addr_reg + AW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // shadow screen: old {char, colour} out, new one in, same cycle
    // ---------------------------------------------------------------
    logic [15:0] sh_rdata;

    tsda_shadow_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_shadow (
        .clk   (clk),
        .en    (in_accept),
        .addr  (addr_reg),
        .wdata ({cell_char, cell_color}),
        .rdata (sh_rdata)
    );

    // ---------------------------------------------------------------
    // compare stage: one cell waits here against the shadow data
    // ---------------------------------------------------------------
    logic           s1_valid_reg, s1_valid_next;
    logic [7:0]     s1_char_reg;
    logic [7:0]     s1_color_reg;
    logic [7:0]     s1_bg_reg;
    logic           s1_force_reg;
    logic           s1_first_reg;
    logic           s1_col0_reg;
    logic [CLW-1:0] s1_col_reg;
    logic [7:0]     s1_row_bcd_reg;
    logic [7:0]     s1_col_bcd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_char_reg    <= cell_char;
            s1_color_reg   <= cell_color;
            s1_bg_reg      <= frame_bg;
            s1_force_reg   <= force_redraw;
            s1_first_reg   <= (col_reg == '0) && (row_reg == '0);
            s1_col0_reg    <= (col_reg == '0);
            s1_col_reg     <= col_reg;
            s1_row_bcd_reg <= row_bcd_reg;
            s1_col_bcd_reg <= col_bcd_reg;
        end
    end

    // frame and cursor bookkeeping
    logic           bg_valid_reg, bg_valid_next;
    logic [7:0]     stored_bg_reg, stored_bg_next;
    logic           redraw_reg, redraw_next;
    logic           last_valid_reg, last_valid_next;
    logic [7:0]     last_color_reg, last_color_next;
    logic [CUW-1:0] cursor_reg, cursor_next;

    logic           bg_cond;
    logic           redraw_eff;
    logic           last_valid_eff;
    logic           changed;
    logic           fg_cond;
    logic [CUW-1:0] cursor_eff;
    logic           need_move;
    logic           s1_go;
    logic           job_valid;
    logic           job_ready;
    tsda_job_t      job;

    // background sequence only on a frame's first cell
    assign bg_cond = s1_first_reg &&
                     (!bg_valid_reg || (stored_bg_reg != s1_bg_reg) || s1_force_reg);
    // the frame start forgets redraw and the last colour sent
    assign redraw_eff     = s1_first_reg ? bg_cond : redraw_reg;
    assign last_valid_eff = !s1_first_reg && last_valid_reg;
    assign changed        = redraw_eff ||
                            (sh_rdata[15:8] != s1_char_reg) ||
                            (sh_rdata[7:0] != s1_color_reg);
    assign fg_cond        = !last_valid_eff || (last_color_reg != s1_color_reg);
    // the cursor is forgotten at the start of every row
    assign cursor_eff     = s1_col0_reg ? '0 : cursor_reg;
    assign need_move      = (cursor_eff != CUW'(s1_col_reg) + CUW'(1));

    assign job.has_bg   = bg_cond;
    assign job.bg_bcd   = palette_bcd(s1_bg_reg[3:0]);
    assign job.has_move = need_move;
    assign job.row_bcd  = s1_row_bcd_reg;
    assign job.col_bcd  = s1_col_bcd_reg;
    assign job.has_fg   = fg_cond;
    assign job.fg_bcd   = palette_bcd(s1_color_reg[3:0]);
    assign job.page_hi  = !charset_upper_reg;
    assign job.ch       = s1_char_reg;

    // unchanged cells leave at once, changed ones wait for the sequencer
    assign job_valid = s1_valid_reg && changed;
    assign s1_go     = s1_valid_reg && (!changed || job_ready);
    assign in_ready  = !s1_valid_reg || s1_go;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        bg_valid_next   = bg_valid_reg;
        stored_bg_next  = stored_bg_reg;
        redraw_next     = redraw_reg;
        last_valid_next = last_valid_reg;
        last_color_next = last_color_reg;
        cursor_next     = cursor_reg;
        if (s1_go)
        begin
            if (s1_first_reg)
            begin
                redraw_next     = bg_cond;
                last_valid_next = 1'b0;
                if (bg_cond)
                begin
                    bg_valid_next  = 1'b1;
                    stored_bg_next = s1_bg_reg;
                end
            end
            if (changed)
            begin
                cursor_next = CUW'(s1_col_reg) + CUW'(2);
                if (fg_cond)
                begin
                    last_valid_next = 1'b1;
                    last_color_next = s1_color_reg;
                end
            end
            else if (s1_col0_reg)
            begin
                cursor_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_valid_reg   <= 1'b0;
            stored_bg_reg  <= 8'h00;
            redraw_reg     <= 1'b0;
            last_valid_reg <= 1'b0;
            last_color_reg <= 8'h00;
            cursor_reg     <= '0;
        end
        else
        begin
            bg_valid_reg   <= bg_valid_next;
            stored_bg_reg  <= stored_bg_next;
            redraw_reg     <= redraw_next;
            last_valid_reg <= last_valid_next;
            last_color_reg <= last_color_next;
            cursor_reg     <= cursor_next;
        end
    end

    // ---------------------------------------------------------------
    // byte sequencer
    // ---------------------------------------------------------------
    tsda_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

`ifndef SYNTHESIS
    a_addr_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (addr_reg == '0) == ((col_reg == '0) && (row_reg == '0)))
        else $error("shadow address out of step with cell position");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CUW'(COLUMNS + 1))
        else $error("cursor column beyond the row");

    a_redraw_set: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && bg_cond |=> redraw_reg && bg_valid_reg)
        else $error("background change did not start a full redraw");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_char_reg)
            && $stable(sh_rdata))
        else $error("waiting cell lost or shadow data changed under it");
`endif

endmodule

FILE: hw/rtl/tsda_shadow_ram.sv
module tsda_shadow_ram #(
    parameter int DEPTH = 1000,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] addr,
    input  logic [15:0]   wdata,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    // read-first: the old entry comes out while the new one goes in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/tsda_emitter.sv
module tsda_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_ready,
    input  tsda_pkg::tsda_job_t job,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_byte
);

    import tsda_pkg::*;

    tsda_step_t state_reg, state_next;
    logic       phase_bg_reg, phase_bg_next;
    tsda_job_t  job_reg;
    logic       load;
    logic       advance;
    logic [11:0] cur_bcd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            phase_bg_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_bg_reg <= phase_bg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
    end

    assign out_valid = (state_reg != ST_IDLE);
    assign advance   = out_valid && out_ready;
    assign job_ready = (state_reg == ST_IDLE) || ((state_reg == ST_G2) && out_ready);
    assign load      = job_valid && job_ready;
    assign last_byte = (state_reg == ST_G2);
    assign cur_bcd   = phase_bg_reg ? job_reg.bg_bcd : job_reg.fg_bcd;

    always_comb
    begin
        state_next    = state_reg;
        phase_bg_next = phase_bg_reg;
        if (advance)
        begin
            case (state_reg)
                ST_C_ESC:   state_next = ST_C_LB;
                ST_C_LB:    state_next = ST_C_KIND;
                ST_C_KIND:  state_next = ST_C_8;
                ST_C_8:     state_next = ST_C_SEMI1;
                ST_C_SEMI1: state_next = ST_C_5;
                ST_C_5:     state_next = ST_C_SEMI2;
                ST_C_SEMI2:
                begin
                    if (cur_bcd[11:8] != 4'd0)
                    begin
                        state_next = ST_C_D2;
                    end
                    else if (cur_bcd[7:4] != 4'd0)
                    begin
                        state_next = ST_C_D1;
                    end
                    else
                    begin
                        state_next = ST_C_D0;
                    end
                end
                ST_C_D2:    state_next = ST_C_D1;
                ST_C_D1:    state_next = ST_C_D0;
                ST_C_D0:    state_next = ST_C_M;
                ST_C_M:
                begin
                    if (phase_bg_reg && job_reg.has_move)
                    begin
                        state_next = ST_M_ESC;
                    end
                    else if (phase_bg_reg && job_reg.has_fg)
                    begin
                        state_next    = ST_C_ESC;
                        phase_bg_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_G0;
                    end
                end
                ST_M_ESC:   state_next = ST_M_LB;
                ST_M_LB:    state_next = (job_reg.row_bcd[7:4] != 4'd0) ? ST_M_ROW1 : ST_M_ROW0;
                ST_M_ROW1:  state_next = ST_M_ROW0;
                ST_M_ROW0:  state_next = ST_M_SEMI;
                ST_M_SEMI:  state_next = (job_reg.col_bcd[7:4] != 4'd0) ? ST_M_COL1 : ST_M_COL0;
                ST_M_COL1:  state_next = ST_M_COL0;
                ST_M_COL0:  state_next = ST_M_H;
                ST_M_H:
                begin
                    if (job_reg.has_fg)
                    begin
                        state_next    = ST_C_ESC;
                        phase_bg_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_G0;
                    end
                end
                ST_G0:      state_next = ST_G1;
                ST_G1:      state_next = ST_G2;
                ST_G2:      state_next = ST_IDLE;
                default:    state_next = ST_IDLE;
            endcase
        end
        // new cell: pick the first sequence it needs
        if (load)
        begin
            phase_bg_next = job.has_bg;
            if (job.has_bg || job.has_fg && !job.has_move)
            begin
                state_next = ST_C_ESC;
            end
            else if (job.has_move)
            begin
                state_next = ST_M_ESC;
            end
            else
            begin
                state_next = ST_G0;
            end
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_C_ESC:   out_byte = CH_ESC;
            ST_C_LB:    out_byte = CH_LBRACKET;
            ST_C_KIND:  out_byte = phase_bg_reg ? CH_FOUR : CH_THREE;
            ST_C_8:     out_byte = CH_EIGHT;
            ST_C_SEMI1: out_byte = CH_SEMI;
            ST_C_5:     out_byte = CH_FIVE;
            ST_C_SEMI2: out_byte = CH_SEMI;
            ST_C_D2:    out_byte = {DIGIT_HI, cur_bcd[11:8]};
            ST_C_D1:    out_byte = {DIGIT_HI, cur_bcd[7:4]};
            ST_C_D0:    out_byte = {DIGIT_HI, cur_bcd[3:0]};
            ST_C_M:     out_byte = CH_LOWER_M;
            ST_M_ESC:   out_byte = CH_ESC;
            ST_M_LB:    out_byte = CH_LBRACKET;
            ST_M_ROW1:  out_byte = {DIGIT_HI, job_reg.row_bcd[7:4]};
            ST_M_ROW0:  out_byte = {DIGIT_HI, job_reg.row_bcd[3:0]};
            ST_M_SEMI:  out_byte = CH_SEMI;
            ST_M_COL1:  out_byte = {DIGIT_HI, job_reg.col_bcd[7:4]};
            ST_M_COL0:  out_byte = {DIGIT_HI, job_reg.col_bcd[3:0]};
            ST_M_H:     out_byte = CH_UPPER_H;
            ST_G0:      out_byte = UTF8_LEAD;
            ST_G1:      out_byte = {UTF8_CONT, 3'b000, job_reg.page_hi, job_reg.ch[7:6]};
            ST_G2:      out_byte = {UTF8_CONT, job_reg.ch[5:0]};
            default:    out_byte = 8'h00;
        endcase
    end

endmodule

FILE: test/tb_text_screen_diff_to_ansi.sv
`timescale 1ns / 1ps

module tb_text_screen_diff_to_ansi;

    // screen geometry as the block is used
    localparam int COLUMNS = 40;
    localparam int ROWS    = 25;
    localparam int SCREEN  = COLUMNS * ROWS;

    // cycles with no transaction at all before the run is called hung
    localparam int QUIET_LIMIT   = 3000;
    // drain time after the last expected byte: one cell may still be in compare
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_MAX    = 10;

    localparam logic [7:0] ESC_CHAR = 8'h1B;

    // directed opening cells: extremes of the character byte, every low nibble
    // of the colour byte, repeated colours and colours differing in the upper
    // nibble only (listed from cell 0 onwards)
    localparam int DIR_COUNT = 25;
    localparam logic [DIR_COUNT*8-1:0] DIR_CHARS = {
        8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h20, 8'h41,
        8'hC0, 8'h3F, 8'h40, 8'hBF, 8'hE0, 8'h1F, 8'h10, 8'hEF, 8'h08, 8'hF7,
        8'h04, 8'hFB, 8'h02, 8'hFD, 8'hFF
    };
    localparam logic [DIR_COUNT*8-1:0] DIR_COLOURS = {
        8'h00, 8'h00, 8'hF1, 8'h02, 8'h13, 8'h03, 8'hA4, 8'h55, 8'hC6, 8'h07,
        8'h38, 8'h89, 8'h9A, 8'hEB, 8'h6C, 8'h1D, 8'h2E, 8'hFF, 8'h0F, 8'hF0,
        8'h70, 8'h71, 8'h81, 8'h91, 8'hF2
    };

    // one byte of the terminal stream plus its end-of-cell mark
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } ansi_byte_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] cell_char;
    logic [7:0] cell_color;
    logic [7:0] frame_bg;
    logic       force_redraw;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       last_byte;

    text_screen_diff_to_ansi #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cell_char    (cell_char),
        .cell_color   (cell_color),
        .frame_bg     (frame_bg),
        .force_redraw (force_redraw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .last_byte    (last_byte)
    );

    // ------------------------------------------------------------------
    // screen model: shadow copy, background, colour and cursor tracking
    // ------------------------------------------------------------------
    logic [7:0] scr_char  [SCREEN];
    logic [7:0] scr_color [SCREEN];
    logic [7:0] bg_held;
    logic       bg_known;
    logic       full_redraw;
    logic [7:0] fg_held;
    logic       fg_known;
    int         cur_col;
    int         row_pos;
    int         col_pos;
    logic       charset_hi;

    // terminal bytes still owed by the block, oldest first
    ansi_byte_t ansi_q [$];

    // sender burst state and content run state
    int         burst_left;
    int         run_left;
    int         run_kind;
    logic [7:0] run_color;

    // bookkeeping for the summary
    int cells_sent;
    int redraws;
    int cfg_writes;
    int bytes_checked;
    int mismatches;

    // receiver stall pattern and watchdog
    int ready_mode;
    int ready_tick;
    int quiet_cycles;

    always #5 clk = ~clk;

    // 256-colour index chosen by the low nibble
    function automatic int xterm_of(input logic [3:0] nib);
        case (nib)
            4'd0:    return 0;
            4'd1:    return 15;
            4'd2:    return 88;
            4'd3:    return 109;
            4'd4:    return 92;
            4'd5:    return 70;
            4'd6:    return 18;
            4'd7:    return 185;
            4'd8:    return 94;
            4'd9:    return 52;
            4'd10:   return 138;
            4'd11:   return 240;
            4'd12:   return 244;
            4'd13:   return 150;
            4'd14:   return 62;
            default: return 248;
        endcase
    endfunction

    task automatic emit(input logic [7:0] b);
        ansi_q.push_back({b, 1'b0});
    endtask

    // decimal without leading zeros
    task automatic emit_dec(input int v);
        if (v >= 100)
            emit(8'h30 + 8'((v / 100) % 10));
        if (v >= 10)
            emit(8'h30 + 8'((v / 10) % 10));
        emit(8'h30 + 8'(v % 10));
    endtask

    // ESC [ k 8 ; 5 ; n m, with k '3' for foreground and '4' for background
    task automatic emit_colour(input logic [7:0] kind, input logic [7:0] v);
        emit(ESC_CHAR);
        emit("[");
        emit(kind);
        emit("8");
        emit(";");
        emit("5");
        emit(";");
        emit_dec(xterm_of(v[3:0]));
        emit("m");
    endtask

    // works out every terminal byte that one accepted cell causes
    task automatic predict_ansi(input logic [7:0] ch, input logic [7:0] co,
                                input logic [7:0] bg, input logic frc);
        int         pos;
        int         start_len;
        logic [15:0] glyph;
        ansi_byte_t tail;
        pos       = row_pos * COLUMNS + col_pos;
        start_len = ansi_q.size();

        // frame start: forget the colour, maybe repaint the background
        if (row_pos == 0 && col_pos == 0)
        begin
            fg_known    = 1'b0;
            full_redraw = 1'b0;
            if (!bg_known || bg_held != bg || frc)
            begin
                full_redraw = 1'b1;
                bg_held     = bg;
                bg_known    = 1'b1;
                emit_colour("4", bg);
                redraws++;
            end
        end
        // row start: cursor position no longer known
        if (col_pos == 0)
            cur_col = 0;

        if (full_redraw || scr_char[pos] != ch || scr_color[pos] != co)
        begin
            glyph          = (charset_hi ? 16'hE000 : 16'hE100) + {8'h00, ch};
            scr_char[pos]  = ch;
            scr_color[pos] = co;
            // cursor move unless this cell follows the last one written
            if (cur_col != col_pos + 1)
            begin
                emit(ESC_CHAR);
                emit("[");
                emit_dec(row_pos + 1);
                emit(";");
                emit_dec(col_pos + 1);
                emit("H");
                cur_col = col_pos + 1;
            end
            if (!fg_known || fg_held != co)
            begin
                fg_held  = co;
                fg_known = 1'b1;
                emit_colour("3", co);
            end
            emit({4'hE, glyph[15:12]});
            emit({2'b10, glyph[11:6]});
            emit({2'b10, glyph[5:0]});
            cur_col++;
        end

        if (ansi_q.size() > start_len)
        begin
            tail     = ansi_q.pop_back();
            tail.fin = 1'b1;
            ansi_q.push_back(tail);
        end

        col_pos++;
        if (col_pos >= COLUMNS)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= ROWS)
                row_pos = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length, random gaps in between
    // ------------------------------------------------------------------
    task automatic send_cell(input logic [7:0] ch, input logic [7:0] co,
                             input logic [7:0] bg, input logic frc);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 20);
        end
        in_valid     <= 1'b1;
        cell_char    <= ch;
        cell_color   <= co;
        frame_bg     <= bg;
        force_redraw <= frc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_ansi(ch, co, bg, frc);
        cells_sent++;
        burst_left--;
    endtask

    // only called once everything owed has arrived
    task automatic write_charset(input logic hi);
        cfg_valid <= 1'b1;
        cfg_data  <= hi;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        charset_hi  = hi;
        cfg_writes++;
    endtask

    // sender pauses until every owed byte is out, then lets the block settle
    task automatic wait_drained;
        in_valid  <= 1'b0;
        burst_left = 0;
        while (ansi_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // next cell content: mostly a repeat of the screen, with runs of changes
    // so that repeated colours and fresh colours both happen
    task automatic pick_content(input int pct, output logic [7:0] ch,
                                output logic [7:0] co);
        int pos;
        pos = row_pos * COLUMNS + col_pos;
        ch  = scr_char[pos];
        co  = scr_color[pos];
        if (run_left == 0 && $urandom_range(1, 100) <= pct)
        begin
            run_left = $urandom_range(1, 6);
            run_kind = $urandom_range(0, 2);
            // sometimes a colour that differs in the upper nibble only
            if ($urandom_range(0, 3) == 0)
                run_color = co ^ 8'($urandom_range(1, 15) << 4);
            else
                run_color = 8'($urandom_range(0, 255));
        end
        if (run_left > 0)
        begin
            run_left--;
            if (run_kind != 1)
                ch = 8'($urandom_range(0, 255));
            if (run_kind != 0)
                co = run_color;
        end
    endtask

    // a stretch of cells; background and redraw fields are noise here
    task automatic send_cells(input int count, input int pct);
        int         k;
        logic [7:0] ch;
        logic [7:0] co;
        for (k = 0; k < count; k++)
        begin
            pick_content(pct, ch, co);
            send_cell(ch, co, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // first frame after reset always repaints: directed opening cells
    task automatic test_first_frame;
        int i;
        write_charset(1'b1);
        for (i = 0; i < DIR_COUNT; i++)
        begin
            if (i == 0)
                send_cell(DIR_CHARS[8*(DIR_COUNT-1-i) +: 8],
                          DIR_COLOURS[8*(DIR_COUNT-1-i) +: 8], 8'hFF, 1'b0);
            else
                send_cell(DIR_CHARS[8*(DIR_COUNT-1-i) +: 8],
                          DIR_COLOURS[8*(DIR_COUNT-1-i) +: 8],
                          (i % 2 == 1) ? 8'h00 : 8'hFF, 1'(i % 2));
        end
    endtask

    // random cells running across the end of the first row
    task automatic test_row_wrap;
        run_left = 0;
        send_cells(30, 100);
    endtask

    // lower glyph page part way through the frame
    task automatic test_charset_switch;
        wait_drained();
        write_charset(1'b0);
        send_cells(25, 100);
    endtask

    // back to the upper page, from the start of the next row
    task automatic test_charset_restore;
        wait_drained();
        write_charset(1'b1);
        send_cells(20, 100);
    endtask

    // ------------------------------------------------------------------
    // receiver: ready follows a stall mode that is re-picked at random as the run goes on
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 150 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= ((ready_tick % 8) < 5);
            default: out_ready <= ((ready_tick % 12) < 3);
        endcase
    end

    // compare each accepted terminal byte with the oldest one owed
    always @(posedge clk)
    begin : take_byte
        ansi_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            bytes_checked++;
            if (ansi_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected byte %02h last %0b, nothing owed",
                             $realtime, out_byte, last_byte);
            end
            else
            begin
                want = ansi_q.pop_front();
                if (want.data !== out_byte || want.fin !== last_byte)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: byte %02h last %0b, expected %02h last %0b",
                                 $realtime, out_byte, last_byte, want.data, want.fin);
                end
            end
        end
    end

    // watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d bytes still owed",
                     QUIET_LIMIT, ansi_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int i;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        in_valid     = 1'b0;
        cell_char    = 8'h00;
        cell_color   = 8'h00;
        frame_bg     = 8'h00;
        force_redraw = 1'b0;
        out_ready    = 1'b0;
        ready_mode   = 0;
        ready_tick   = 0;
        quiet_cycles = 0;

        // model state after reset
        for (i = 0; i < SCREEN; i++)
        begin
            scr_char[i]  = 8'h00;
            scr_color[i] = 8'h00;
        end
        bg_held       = 8'h00;
        bg_known      = 1'b0;
        full_redraw   = 1'b0;
        fg_held       = 8'h00;
        fg_known      = 1'b0;
        cur_col       = 0;
        row_pos       = 0;
        col_pos       = 0;
        charset_hi    = 1'b1;
        burst_left    = 0;
        run_left      = 0;
        run_kind      = 0;
        run_color     = 8'h00;
        cells_sent    = 0;
        redraws       = 0;
        cfg_writes    = 0;
        bytes_checked = 0;
        mismatches    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_frame();
        test_row_wrap();
        test_charset_switch();
        test_charset_restore();

        wait_drained();

        $display("summary: %0d cells of the opening rows, %0d background repaints",
                 cells_sent, redraws);
        $display("summary: %0d terminal bytes checked, %0d glyph page writes, %0d mismatches",
                 bytes_checked, cfg_writes, mismatches);
        if (mismatches == 0 && ansi_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
